### src/assert_macros.svh
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off during reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Implication whose consequent is checked at the next rising clock edge, off during reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/ppp_pkg.sv
// Types, widths and register codes of the pinhole point projector.
`default_nettype none
package ppp_pkg;

   localparam int COORD_W      = 32;
   localparam int ROT_W        = 16;
   localparam int ROT_FRAC     = 14;
   localparam int ROW_W        = 3 * ROT_W;
   localparam int PROD_W       = COORD_W + ROT_W;
   localparam int ACC_W        = PROD_W + 3;
   localparam int CAM_W        = ACC_W - ROT_FRAC;
   localparam int FOC_W        = 16;
   localparam int MUL_W        = FOC_W + 1 + CAM_W;
   localparam int SUM_W        = MUL_W + 1;
   localparam int NUM_W        = SUM_W + 3;
   localparam int DEN_W        = CAM_W + 5;
   localparam int PIX_W        = 12;
   localparam int DEPTH_W      = 31;
   localparam int SIZE_W       = 24;
   localparam int MAX_DIM_BITS = 16;
   localparam int IMAGE_DIM_BITS_DEF = 12;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   localparam logic [CSR_IDX_W-1:0] REG_FOCAL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRINCIPAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Z      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_XY   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_Z    = 3'd7;

   localparam logic [ROW_W-1:0] ROT_X_RESET = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ROT_Y_RESET = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROT_Z_RESET = 48'h4000_0000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic signed [COORD_W-1:0] world_z;
      logic                      point_valid;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic [PIX_W-1:0]   pixel_col;
      logic [PIX_W-1:0]   pixel_row;
      logic [DEPTH_W-1:0] point_depth;
   } rsp_type;

   typedef struct packed {
      logic                    keep;
      logic signed [CAM_W-1:0] xc;
      logic signed [CAM_W-1:0] yc;
      logic signed [CAM_W-1:0] zc;
   } cam_type;

   typedef struct packed {
      logic                    keep;
      logic                    neg_x;
      logic                    neg_y;
      logic [NUM_W-1:0]        rem_x;
      logic [NUM_W-1:0]        rem_y;
      logic [DEN_W-1:0]        den;
      logic [MAX_DIM_BITS-1:0] q_x;
      logic [MAX_DIM_BITS-1:0] q_y;
      logic [DEPTH_W-1:0]      depth;
   } div_type;

endpackage
`default_nettype wire

### src/ppp_xform.sv
// Rotation and translation into camera space: multiply stage, then sum and floor stage.
`default_nettype none
module ppp_xform (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  ppp_pkg::req_type            in_data,
   output logic                        in_ready,
   input  logic [ppp_pkg::ROW_W-1:0]   rot_x,
   input  logic [ppp_pkg::ROW_W-1:0]   rot_y,
   input  logic [ppp_pkg::ROW_W-1:0]   rot_z,
   input  logic [2*ppp_pkg::COORD_W-1:0] trans_xy,
   input  logic [ppp_pkg::COORD_W-1:0] trans_z,
   output logic                        out_valid,
   output ppp_pkg::cam_type            out_data,
   input  logic                        out_ready
);
   import ppp_pkg::*;

   logic                      v1_ff, v1_in, ld1;
   logic                      keep1_ff;
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [PROD_W-1:0]  prod_in [3][3];
   logic signed [COORD_W-1:0] t_ff [3];
   logic                      v2_ff, v2_in, ld2;
   cam_type                   cam_ff, cam_in;
   logic signed [COORD_W-1:0] w [3];
   logic [ROW_W-1:0]          rows [3];
   logic signed [ACC_W-1:0]   acc [3];
   logic signed [CAM_W-1:0]   cam [3];

   assign ld2      = !v2_ff || out_ready;
   assign ld1      = !v1_ff || ld2;
   assign in_ready = ld1;
   assign v1_in    = ld1 ? in_valid : v1_ff;
   assign v2_in    = ld2 ? v1_ff : v2_ff;

   always_comb begin
      w[0] = in_data.world_x;
      w[1] = in_data.world_y;
      w[2] = in_data.world_z;
      rows[0] = rot_x;
      rows[1] = rot_y;
      rows[2] = rot_z;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[j][k] = PROD_W'($signed(rows[j][ROT_W*k +: ROT_W])) * PROD_W'(w[k]);
         end
      end
   end

   // Exact sum, then floor back to the input fraction width.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         acc[j] = (ACC_W'(t_ff[j]) <<< ROT_FRAC) + ACC_W'(prod_ff[j][0])
                + ACC_W'(prod_ff[j][1]) + ACC_W'(prod_ff[j][2]);
         cam[j] = CAM_W'(acc[j] >>> ROT_FRAC);
      end
      cam_in.keep = keep1_ff;
      cam_in.xc   = cam[0];
      cam_in.yc   = cam[1];
      cam_in.zc   = cam[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && in_valid) begin
         prod_ff  <= prod_in;
         keep1_ff <= in_data.point_valid;
         t_ff[0]  <= $signed(trans_xy[COORD_W-1:0]);
         t_ff[1]  <= $signed(trans_xy[2*COORD_W-1:COORD_W]);
         t_ff[2]  <= $signed(trans_z);
      end
      if (ld2 && v1_ff) begin
         cam_ff <= cam_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = cam_ff;
endmodule
`default_nettype wire

### src/ppp_project.sv
// Focal scaling and numerator/denominator setup for the rounding divide.
`default_nettype none
module ppp_project #(
   parameter int IMAGE_DIM_BITS = ppp_pkg::IMAGE_DIM_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ppp_pkg::cam_type          in_data,
   output logic                      in_ready,
   input  logic [2*ppp_pkg::FOC_W-1:0] focal,
   input  logic [2*ppp_pkg::FOC_W-1:0] principal,
   output logic                      out_valid,
   output ppp_pkg::div_type          out_data,
   input  logic                      out_ready
);
   import ppp_pkg::*;

   logic                    v3_ff, v4_ff, v5_ff, v3_in, v4_in, v5_in, ld3, ld4, ld5;
   logic                    keep3_ff, keep4_ff;
   logic signed [CAM_W-1:0] z3_ff, z4_ff;
   logic signed [MUL_W-1:0] m_fx_ff, m_cx_ff, m_fy_ff, m_cy_ff;
   logic signed [SUM_W-1:0] nx_ff, ny_ff;
   div_type                 div_ff, div_in;
   logic                    zpos;
   logic [CAM_W-2:0]        zmag;
   logic [SUM_W-1:0]        mag_x, mag_y;
   logic [NUM_W-1:0]        den_top;
   logic                    ovf_x, ovf_y;

   assign ld5      = !v5_ff || out_ready;
   assign ld4      = !v4_ff || ld5;
   assign ld3      = !v3_ff || ld4;
   assign in_ready = ld3;
   assign v3_in    = ld3 ? in_valid : v3_ff;
   assign v4_in    = ld4 ? v3_ff : v4_ff;
   assign v5_in    = ld5 ? v4_ff : v5_ff;

   assign zpos = !in_data.zc[CAM_W-1] && (in_data.zc != '0);

   // round_half_away(n / d) becomes floor((2|n| + d) / 2d), d = 16 z.
   always_comb begin
      zmag         = z4_ff[CAM_W-2:0];
      div_in.neg_x = nx_ff[SUM_W-1];
      div_in.neg_y = ny_ff[SUM_W-1];
      mag_x        = div_in.neg_x ? SUM_W'(-nx_ff) : SUM_W'(nx_ff);
      mag_y        = div_in.neg_y ? SUM_W'(-ny_ff) : SUM_W'(ny_ff);
      div_in.rem_x = (NUM_W'(mag_x) << 1) + (NUM_W'(zmag) << 4);
      div_in.rem_y = (NUM_W'(mag_y) << 1) + (NUM_W'(zmag) << 4);
      div_in.den   = DEN_W'(zmag) << 5;
      den_top      = NUM_W'(div_in.den) << IMAGE_DIM_BITS;
      ovf_x        = div_in.rem_x >= den_top;
      ovf_y        = div_in.rem_y >= den_top;
      div_in.keep  = keep4_ff && !ovf_x && !ovf_y;
      div_in.q_x   = '0;
      div_in.q_y   = '0;
      div_in.depth = (|zmag[CAM_W-2:DEPTH_W]) ? {DEPTH_W{1'b1}} : zmag[DEPTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld3 && in_valid) begin
         keep3_ff <= in_data.keep && zpos;
         z3_ff    <= in_data.zc;
         m_fx_ff  <= MUL_W'($signed({1'b0, focal[FOC_W-1:0]})) * MUL_W'(in_data.xc);
         m_cx_ff  <= MUL_W'($signed({1'b0, principal[FOC_W-1:0]})) * MUL_W'(in_data.zc);
         m_fy_ff  <= MUL_W'($signed({1'b0, focal[2*FOC_W-1:FOC_W]})) * MUL_W'(in_data.yc);
         m_cy_ff  <= MUL_W'($signed({1'b0, principal[2*FOC_W-1:FOC_W]}))
                     * MUL_W'(in_data.zc);
      end
      if (ld4 && v3_ff) begin
         keep4_ff <= keep3_ff;
         z4_ff    <= z3_ff;
         nx_ff    <= SUM_W'(m_fx_ff) + SUM_W'(m_cx_ff);
         ny_ff    <= SUM_W'(m_fy_ff) + SUM_W'(m_cy_ff);
      end
      if (ld5 && v4_ff) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = div_ff;
endmodule
`default_nettype wire

### src/ppp_div_step.sv
// One restoring-division stage: resolves one quotient bit for x and for y.
`default_nettype none
module ppp_div_step #(
   parameter int BIT_POS = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ppp_pkg::div_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output ppp_pkg::div_type out_data,
   input  logic             out_ready
);
   import ppp_pkg::*;

   logic             v_ff, v_in, ld;
   div_type          d_ff, d_in;
   logic [NUM_W-1:0] dsh;
   logic             ge_x, ge_y;

   assign ld       = !v_ff || out_ready;
   assign in_ready = ld;
   assign v_in     = ld ? in_valid : v_ff;

   always_comb begin
      dsh  = NUM_W'(in_data.den) << BIT_POS;
      ge_x = in_data.rem_x >= dsh;
      ge_y = in_data.rem_y >= dsh;
      d_in = in_data;
      d_in.rem_x = ge_x ? in_data.rem_x - dsh : in_data.rem_x;
      d_in.rem_y = ge_y ? in_data.rem_y - dsh : in_data.rem_y;
      d_in.q_x[BIT_POS] = ge_x;
      d_in.q_y[BIT_POS] = ge_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld && in_valid) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;
endmodule
`default_nettype wire

### src/pinhole_point_projector.sv
// Top level of the pinhole point projector: registers, pipeline chain, range check.
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | req_data  (world point + valid flag)
//  rsp_     | out       | rsp_valid/rsp_stall  | rsp_data  (visible, pixel, depth)
//  csr_     | in        | csr_we               | csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_stall is low. Pipeline stages:
// 2 transform, 3 projection, one per quotient bit, 1 output register.
// The divide stage count is set by IMAGE_DIM_BITS: one quotient bit per stage.
// Synchronous reset clears the stage valid bits and config registers (rotation rows
// reset to identity). A stall holds only full stages; bubbles ahead still close up.
`default_nettype none
`include "assert_macros.svh"
module pinhole_point_projector #(
   parameter int IMAGE_DIM_BITS = ppp_pkg::IMAGE_DIM_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ppp_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppp_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ppp_pkg::*;

   localparam int DIM = IMAGE_DIM_BITS;

   // configuration registers
   logic [2*FOC_W-1:0]   focal_ff, principal_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [ROW_W-1:0]     rot_x_ff, rot_y_ff, rot_z_ff;
   logic [2*COORD_W-1:0] trans_xy_ff;
   logic [COORD_W-1:0]   trans_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff     <= '0;
         principal_ff <= '0;
         size_ff      <= '0;
         rot_x_ff     <= ROT_X_RESET;
         rot_y_ff     <= ROT_Y_RESET;
         rot_z_ff     <= ROT_Z_RESET;
         trans_xy_ff  <= '0;
         trans_z_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FOCAL:      focal_ff     <= csr_wdata[2*FOC_W-1:0];
            REG_PRINCIPAL:  principal_ff <= csr_wdata[2*FOC_W-1:0];
            REG_IMAGE_SIZE: size_ff      <= csr_wdata[SIZE_W-1:0];
            REG_ROT_X:      rot_x_ff     <= csr_wdata[ROW_W-1:0];
            REG_ROT_Y:      rot_y_ff     <= csr_wdata[ROW_W-1:0];
            REG_ROT_Z:      rot_z_ff     <= csr_wdata[ROW_W-1:0];
            REG_TRANS_XY:   trans_xy_ff  <= csr_wdata[2*COORD_W-1:0];
            REG_TRANS_Z:    trans_z_ff   <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // camera-space transform
   logic    xf_ready, cam_valid, cam_ready;
   cam_type cam_data;

   assign req_stall = !xf_ready;

   ppp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (xf_ready),
      .rot_x     (rot_x_ff),
      .rot_y     (rot_y_ff),
      .rot_z     (rot_z_ff),
      .trans_xy  (trans_xy_ff),
      .trans_z   (trans_z_ff),
      .out_valid (cam_valid),
      .out_data  (cam_data),
      .out_ready (cam_ready)
   );

   // chain of divide stages; index 0 is the projection output
   logic    div_valid [DIM+1];
   logic    div_ready [DIM+1];
   div_type div_data  [DIM+1];

   ppp_project #(
      .IMAGE_DIM_BITS (IMAGE_DIM_BITS)
   ) u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cam_valid),
      .in_data   (cam_data),
      .in_ready  (cam_ready),
      .focal     (focal_ff),
      .principal (principal_ff),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0]),
      .out_ready (div_ready[0])
   );

   for (genvar i = 0; i < DIM; i++) begin : g_div
      ppp_div_step #(
         .BIT_POS (DIM - 1 - i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_data   (div_data[i]),
         .in_ready  (div_ready[i]),
         .out_valid (div_valid[i+1]),
         .out_data  (div_data[i+1]),
         .out_ready (div_ready[i+1])
      );
   end

   // range check and output register
   logic [2*MAX_DIM_BITS-1:0] size_ext;
   logic [DIM-1:0]            img_width, img_height, qx, qy;
   logic                      vis, out_ld;
   logic                      out_v_ff, out_v_in;
   rsp_type                   out_ff, out_in;
   div_type                   fin;

   assign size_ext   = (2*MAX_DIM_BITS)'(size_ff);
   assign img_width  = size_ext[DIM-1:0];
   assign img_height = size_ext[2*DIM-1:DIM];
   assign fin        = div_data[DIM];
   assign qx         = fin.q_x[DIM-1:0];
   assign qy         = fin.q_y[DIM-1:0];

   // a negative numerator stays in the image only when it rounds to zero
   assign vis = fin.keep && (!fin.neg_x || qx == '0) && (!fin.neg_y || qy == '0)
             && (qx < img_width) && (qy < img_height);

   always_comb begin
      out_in.visible     = vis;
      out_in.pixel_col   = vis ? PIX_W'(fin.q_x) : '0;
      out_in.pixel_row   = vis ? PIX_W'(fin.q_y) : '0;
      out_in.point_depth = vis ? fin.depth : '0;
   end

   assign out_ld         = !out_v_ff || !rsp_stall;
   assign div_ready[DIM] = out_ld;
   assign out_v_in       = out_ld ? div_valid[DIM] : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ld && div_valid[DIM]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   `ASSERT_IMPLY(a_vis_depth, rsp_valid && rsp_data.visible, rsp_data.point_depth != '0, "visible result with zero depth")
   `ASSERT_IMPLY(a_hidden_zero, rsp_valid && !rsp_data.visible, rsp_data.pixel_col == '0 && rsp_data.pixel_row == '0 && rsp_data.point_depth == '0, "hidden result with nonzero fields")
   `ASSERT_IMPLY(a_vis_range, rsp_valid && rsp_data.visible, 32'(rsp_data.pixel_col) < 32'(img_width) && 32'(rsp_data.pixel_row) < 32'(img_height), "visible pixel outside image")
   `ASSERT_NEXT(a_out_load, out_ld && div_valid[DIM], rsp_valid, "finished transaction not presented")
endmodule
`default_nettype wire

### tb/pinhole_point_projector_test.sv
// Self-checking testbench for the pinhole point projector.
`timescale 1ns / 1ps
`default_nettype none
module pinhole_point_projector_test;
   import ppp_pkg::*;

   localparam int LATENCY     = 18;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [31:0] ONE_M = 32'h0001_0000;   // 1.0 in Q16.16

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_FOCAL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the register file
   logic [31:0] focal_q, principal_q;
   logic [23:0] image_size_q;
   logic [47:0] rot_rows_q [3];
   logic signed [31:0] trans_q [3];

   rsp_type pixels_expected [$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;   // receiver hold-off cycles left

   pinhole_point_projector u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("pinhole_point_projector_test NOT OK");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off while it is counting down
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // round half away from zero, d > 0
   function automatic longint div_round_away(longint n, longint d);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   // world point to pixel, on the shadow registers
   function automatic rsp_type project_point(req_type p);
      longint w [3];
      longint cam [3];
      longint acc, nx, ny, u, v;
      shortint entry;
      rsp_type o;
      o = '0;
      if (!p.point_valid) return o;
      w[0] = p.world_x;
      w[1] = p.world_y;
      w[2] = p.world_z;
      for (int r = 0; r < 3; r++) begin
         acc = longint'(trans_q[r]) * 16384;
         for (int k = 0; k < 3; k++) begin
            entry = rot_rows_q[r][16*k +: 16];
            acc += longint'(entry) * w[k];
         end
         cam[r] = acc >>> ROT_FRAC;   // floor
      end
      if (cam[2] <= 0) return o;
      nx = longint'(focal_q[15:0]) * cam[0] + longint'(principal_q[15:0]) * cam[2];
      ny = longint'(focal_q[31:16]) * cam[1] + longint'(principal_q[31:16]) * cam[2];
      u = div_round_away(nx, 16 * cam[2]);
      v = div_round_away(ny, 16 * cam[2]);
      if (u < 0 || u >= longint'(image_size_q[11:0]) ||
          v < 0 || v >= longint'(image_size_q[23:12])) return o;
      o.visible     = 1'b1;
      o.pixel_col   = u[11:0];
      o.pixel_row   = v[11:0];
      o.point_depth = (cam[2] > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : cam[2][30:0];
      return o;
   endfunction

   // result checker: a transaction completes at the edge after this sample
   always @(negedge clock) begin
      rsp_type exp_pix;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixels_expected.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            exp_pix = pixels_expected.pop_front();
            if (rsp_data.visible !== exp_pix.visible) begin
               $error("visible: expected %0d actual %0d", exp_pix.visible, rsp_data.visible);
               errors++;
            end
            if (rsp_data.pixel_col !== exp_pix.pixel_col) begin
               $error("pixel_col: expected %0d actual %0d",
                      exp_pix.pixel_col, rsp_data.pixel_col);
               errors++;
            end
            if (rsp_data.pixel_row !== exp_pix.pixel_row) begin
               $error("pixel_row: expected %0d actual %0d",
                      exp_pix.pixel_row, rsp_data.pixel_row);
               errors++;
            end
            if (rsp_data.point_depth !== exp_pix.point_depth) begin
               $error("point_depth: expected %0h actual %0h",
                      exp_pix.point_depth, rsp_data.point_depth);
               errors++;
            end
         end
      end
   end

   // offer one point, idling at random cycles first; returns once accepted
   task automatic send_point(req_type p);
      logic stalled;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do begin
         @(negedge clock);
         stalled = req_stall;
         if (!stalled) pixels_expected = {pixels_expected, project_point(p)};
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      while (pixels_expected.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // register write; only called while the pipeline is empty
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_FOCAL:      focal_q      = value[31:0];
         REG_PRINCIPAL:  principal_q  = value[31:0];
         REG_IMAGE_SIZE: image_size_q = value[23:0];
         REG_ROT_X:      rot_rows_q[0] = value[47:0];
         REG_ROT_Y:      rot_rows_q[1] = value[47:0];
         REG_ROT_Z:      rot_rows_q[2] = value[47:0];
         REG_TRANS_XY: begin
            trans_q[0] = value[31:0];
            trans_q[1] = value[63:32];
         end
         REG_TRANS_Z:    trans_q[2]   = value[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic ok);
      req_type p;
      p.world_x = x;
      p.world_y = y;
      p.world_z = z;
      p.point_valid = ok;
      return p;
   endfunction

   // 640x480 camera, f = 100 px, principal point at the center
   task automatic load_vga_camera();
      write_reg(REG_FOCAL, {32'd0, 16'd1600, 16'd1600});
      write_reg(REG_PRINCIPAL, {32'd0, 16'd3840, 16'd5120});
      write_reg(REG_IMAGE_SIZE, {40'd0, 12'd480, 12'd640});
      write_reg(REG_ROT_X, {16'd0, ROT_X_RESET});
      write_reg(REG_ROT_Y, {16'd0, ROT_Y_RESET});
      write_reg(REG_ROT_Z, {16'd0, ROT_Z_RESET});
      write_reg(REG_TRANS_XY, 64'd0);
      write_reg(REG_TRANS_Z, 64'd0);
   endtask

   // points at reset settings: zero image size hides everything
   task automatic test_reset_defaults();
      send_point(make_point(32'd0, 32'd0, ONE_M, 1'b1));
      send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, ONE_M, 1'b1));
      end_burst();
   endtask

   task automatic test_directed_cases();
      load_vga_camera();
      send_point(make_point(32'd0, 32'd0, ONE_M, 1'b1));          // center
      send_point(make_point(32'd0, 32'd0, ONE_M, 1'b0));          // invalid flag
      send_point(make_point(32'd0, 32'd0, 32'd0, 1'b1));          // zero depth
      send_point(make_point(32'd0, 32'd0, 32'hFFFF_0000, 1'b1));  // behind camera
      send_point(make_point(32'd0, 32'd0, 32'd1, 1'b1));          // tiny depth
      send_point(make_point(32'h0004_0000, 32'd0, ONE_M, 1'b1));  // off the right edge
      send_point(make_point(32'hFFFC_0000, 32'd0, ONE_M, 1'b1));  // off the left edge
      send_point(make_point(32'h0000_8000, 32'h0000_8000, ONE_M, 1'b1));
      // about -0.005 m: just under half a pixel off the center row
      send_point(make_point(32'd0, 32'hFFFF_FEB9, ONE_M, 1'b1));
      send_point(make_point(32'h0000_0148, 32'h0000_0147, ONE_M, 1'b1));
      send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      send_point(make_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      end_burst();
      // z row scaled near 2 so the first point's depth saturates
      write_reg(REG_ROT_Z, {16'd0, 16'h7FFF, 16'h0000, 16'h0000});
      send_point(make_point(32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1));
      send_point(make_point(32'd0, 32'd0, 32'h4000_0000, 1'b1));
      end_burst();
      // negative-most rotation entries and translation extremes
      write_reg(REG_ROT_Z, {16'd0, 16'h8000, 16'h8000, 16'h8000});
      write_reg(REG_TRANS_Z, 64'h0000_0000_7FFF_FFFF);
      write_reg(REG_TRANS_XY, {32'h8000_0000, 32'h7FFF_FFFF});
      send_point(make_point(32'd0, 32'd0, 32'd0, 1'b1));
      send_point(make_point(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b1));
      end_burst();
      // full image size and full focal / principal words
      load_vga_camera();
      write_reg(REG_IMAGE_SIZE, 64'h00FF_FFFF);
      write_reg(REG_FOCAL, 64'hFFFF_FFFF);
      write_reg(REG_PRINCIPAL, 64'hFFFF_FFFF);
      send_point(make_point(32'd0, 32'd0, ONE_M, 1'b1));
      send_point(make_point(32'h0000_1000, 32'h0000_1000, 32'h0100_0000, 1'b1));
      end_burst();
   endtask

   function automatic logic [15:0] near_unit_entry(bit diag);
      int delta;
      delta = $urandom_range(2000) - 1000;
      return diag ? 16'(16384 + delta) : 16'(delta);
   endfunction

   // random camera: mostly sane, sometimes pure noise
   task automatic load_random_camera();
      logic [63:0] value;
      if ($urandom_range(3) == 0) begin
         write_reg(REG_ROT_X, {$urandom, $urandom});
         write_reg(REG_ROT_Y, {$urandom, $urandom});
         write_reg(REG_ROT_Z, {$urandom, $urandom});
         write_reg(REG_TRANS_XY, {$urandom, $urandom});
         write_reg(REG_TRANS_Z, {$urandom, $urandom});
         write_reg(REG_FOCAL, {$urandom, $urandom});
         write_reg(REG_PRINCIPAL, {$urandom, $urandom});
         write_reg(REG_IMAGE_SIZE, {$urandom, $urandom});
      end else begin
         write_reg(REG_ROT_X, {16'd0, near_unit_entry(0), near_unit_entry(0), near_unit_entry(1)});
         write_reg(REG_ROT_Y, {16'd0, near_unit_entry(0), near_unit_entry(1), near_unit_entry(0)});
         write_reg(REG_ROT_Z, {16'd0, near_unit_entry(1), near_unit_entry(0), near_unit_entry(0)});
         value = {32'($signed($urandom_range(131072)) - 65536),
                  32'($signed($urandom_range(131072)) - 65536)};
         write_reg(REG_TRANS_XY, value);
         write_reg(REG_TRANS_Z, 64'($urandom_range(65536)));
         value[15:0]  = 16'($urandom_range(16000, 800));
         value[31:16] = 16'($urandom_range(16000, 800));
         write_reg(REG_FOCAL, {32'd0, value[31:0]});
         value[15:0]  = 16'($urandom_range(30000));
         value[31:16] = 16'($urandom_range(30000));
         write_reg(REG_PRINCIPAL, {32'd0, value[31:0]});
         write_reg(REG_IMAGE_SIZE, {40'd0, 12'($urandom_range(4095, 200)),
                                    12'($urandom_range(4095, 200))});
      end
   endtask

   // points in front of the camera mostly; a quarter raw noise
   function automatic req_type random_point();
      int z, spread;
      if ($urandom_range(3) == 0)
         return make_point($urandom, $urandom, $urandom, 1'($urandom));
      z = $urandom_range(32'h0100_0000, 32'h0000_1000);
      spread = z;
      return make_point(32'($signed($urandom_range(2 * spread)) - spread),
                        32'($signed($urandom_range(2 * spread)) - spread),
                        32'(z), ($urandom_range(15) != 0));
   endfunction

   task automatic test_random_phase(int sender_pct, int receiver_pct, bit long_hold);
      for (int batch = 0; batch < 3; batch++) begin
         load_random_camera();
         send_idle_pct = sender_pct;
         recv_idle_pct = receiver_pct;
         if (long_hold && batch == 0) hold_off = 300;
         for (int n = 0; n < 50; n++) send_point(random_point());
         end_burst();
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   initial begin
      focal_q = '0;
      principal_q = '0;
      image_size_q = '0;
      rot_rows_q[0] = ROT_X_RESET;
      rot_rows_q[1] = ROT_Y_RESET;
      rot_rows_q[2] = ROT_Z_RESET;
      trans_q[0] = '0;
      trans_q[1] = '0;
      trans_q[2] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_cases();
      test_random_phase(28, 69, 1'b1);
      test_random_phase(69, 28, 1'b0);
      test_random_phase(0, 0, 1'b0);

      if (errors == 0) begin
         $display("pinhole_point_projector_test OK");
      end else begin
         $display("pinhole_point_projector_test NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
+incdir+src
src/ppp_pkg.sv
src/ppp_xform.sv
src/ppp_project.sv
src/ppp_div_step.sv
src/pinhole_point_projector.sv
tb/pinhole_point_projector_test.sv
